// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Bodies are empty in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge outside reset
`define ASSERT_CLK(lbl, clk_sig, rst_sig, prop) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) \
    else $error("assertion failed");

// Condition never holds at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk_sig, rst_sig, cond) \
  `ASSERT_CLK(lbl, clk_sig, rst_sig, !(cond))

`else

`define ASSERT_CLK(lbl, clk_sig, rst_sig, prop)
`define ASSERT_NEVER(lbl, clk_sig, rst_sig, cond)

`endif

`endif

// ===== rtl/kltl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kltl_pkg
// Shared constants, command codes and record types of the layer-tap controller.
// ----------------------------------------------------------------------------
package kltl_pkg;

  localparam int KEY_COUNT  = 80;
  localparam int KEY_BITS   = $clog2(KEY_COUNT);
  localparam int CNT_BITS   = $clog2(KEY_COUNT + 1);
  localparam int TIME_BITS  = 32;
  localparam int GEN_BITS   = 16;

  // fixed field widths of the channels
  localparam int CMD_BITS    = 3;
  localparam int POS_BITS    = 7;
  localparam int LAYER_BITS  = 3;
  localparam int ACTIVE_BITS = 5;
  localparam int TS_BITS     = 32;
  localparam int TAP_BITS    = 16;
  localparam int SCNT_BITS   = 7;
  localparam int CFG_BITS    = 16;

  // event commands
  typedef enum logic [CMD_BITS-1:0] {
    CMD_LAYER_PRESS   = 3'd0,
    CMD_LAYER_RELEASE = 3'd1,
    CMD_MAGIC_PRESS   = 3'd2,
    CMD_MAGIC_RELEASE = 3'd3,
    CMD_ACTIVITY      = 3'd4,
    CMD_SHIFT_PRESS   = 3'd5,
    CMD_SHIFT_RELEASE = 3'd6
  } cmd_t;

  // configuration register indexes
  localparam logic CFG_TAP_WINDOW  = 1'b0;
  localparam logic CFG_MAGIC_LAYER = 1'b1;

  localparam logic [TAP_BITS-1:0]    TAP_WINDOW_RST  = 16'd200;
  localparam logic [ACTIVE_BITS-1:0] MAGIC_LAYER_RST = 5'd3;

  // layer codes; a layer key may request LAYER_1, LAYER_2 or LAYER_4
  localparam logic [LAYER_BITS-1:0] LAYER_NONE = 3'd0;
  localparam logic [LAYER_BITS-1:0] LAYER_1    = 3'd1;
  localparam logic [LAYER_BITS-1:0] LAYER_2    = 3'd2;
  localparam logic [LAYER_BITS-1:0] LAYER_4    = 3'd4;

  // shift side held at a position
  localparam logic [1:0] SHIFT_NONE  = 2'd0;
  localparam logic [1:0] SHIFT_LEFT  = 2'd1;
  localparam logic [1:0] SHIFT_RIGHT = 2'd2;

  typedef struct packed {
    logic elig;
    logic taprdy;
    logic used;
    logic magic;
    logic down;
  } key_flags_t;

  typedef struct packed {
    logic [LAYER_BITS-1:0] layer;
    logic [TIME_BITS-1:0]  press;
    logic [TIME_BITS-1:0]  release_t;
    logic [GEN_BITS-1:0]   gen;
    logic [1:0]            shift;
  } key_rec_t;

endpackage

// ===== rtl/kltl_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kltl_ifs
// Valid/ready channels for key event requests and controller responses.
// ----------------------------------------------------------------------------
interface kltl_req_if;
  logic                              valid;
  logic                              ready;
  logic [kltl_pkg::CMD_BITS-1:0]     cmd;
  logic [kltl_pkg::POS_BITS-1:0]     key_position;
  logic [kltl_pkg::LAYER_BITS-1:0]   layer_number;
  logic [kltl_pkg::TS_BITS-1:0]      timestamp_ms;
  logic                              shift_side;

  modport source (output valid, cmd, key_position, layer_number, timestamp_ms,
                  shift_side, input ready);
  modport sink (input valid, cmd, key_position, layer_number, timestamp_ms,
                shift_side, output ready);
endinterface

interface kltl_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               accepted;
  logic                               magic_tap;
  logic                               caps_latch_now;
  logic [kltl_pkg::ACTIVE_BITS-1:0]   active_layer;
  logic [kltl_pkg::LAYER_BITS-1:0]    locked_layer;
  logic                               owner_valid;
  logic [kltl_pkg::POS_BITS-1:0]      owner_key;

  modport source (output valid, accepted, magic_tap, caps_latch_now, active_layer,
                  locked_layer, owner_valid, owner_key, input ready);
  modport sink (input valid, accepted, magic_tap, caps_latch_now, active_layer,
                locked_layer, owner_valid, owner_key, output ready);
endinterface

// ===== rtl/kltl_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kltl_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module kltl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/keyboard_layer_tap_lock_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_layer_tap_lock_controller
// Layer tap, lock and caps latch control over per-key records held in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one key event (command, position, layer, time, shift side);
//   rsp returns one response per request with the layer state after it.
//   cfg_we/cfg_index/cfg_data write the tap window and the magic layer; write
//   them only while no request is in flight.
// Sequencing:
//   A request is captured in ST_IDLE, evaluated in ST_EVAL and answered from
//   ST_COMMIT. Accepted layer press, magic press and activity requests pass
//   ST_SWEEP on the way, sweeping the key flag RAM once (read-modify-write of
//   every key but the event's own, one entry per cycle). One request is in
//   work at a time; req is ready again when the response is registered.
// Reset:
//   rst clears all layer state; per-key valid bits make every record read as
//   zero until it is first written, so no clearing pass is needed.
// Stall:
//   A finished response waits in the output register; the next request may
//   be accepted, but its own result waits until rsp.ready takes the previous.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keyboard_layer_tap_lock_controller (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [kltl_pkg::CFG_BITS-1:0] cfg_data,
  kltl_req_if.sink                      req,
  kltl_rsp_if.source                    rsp
);

  typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_SWEEP, ST_COMMIT} state_t;

  state_t state;

  // configuration
  logic [kltl_pkg::TAP_BITS-1:0]    tap_window;
  logic [kltl_pkg::ACTIVE_BITS-1:0] magic_layer;

  // captured request
  logic [kltl_pkg::CMD_BITS-1:0]   cmd_q;
  logic [kltl_pkg::POS_BITS-1:0]   pos_q;
  logic [kltl_pkg::LAYER_BITS-1:0] layer_q;
  logic [kltl_pkg::TIME_BITS-1:0]  now_q;
  logic                            side_q;
  logic                            in_range_q;

  // global layer state
  logic [kltl_pkg::ACTIVE_BITS-1:0] active_layer, active_next;
  logic [kltl_pkg::LAYER_BITS-1:0]  locked_layer, locked_next;
  logic                             owner_valid, owner_valid_next;
  logic [kltl_pkg::POS_BITS-1:0]    owner_key, owner_key_next;
  logic [kltl_pkg::GEN_BITS-1:0]    gen, gen_next;
  logic                             caps_set, caps_set_next;
  logic [kltl_pkg::SCNT_BITS-1:0]   shift_cnt [2];
  logic [kltl_pkg::SCNT_BITS-1:0]   shift_cnt_next [2];
  logic [kltl_pkg::CNT_BITS-1:0]    magic_cnt, magic_cnt_next;

  // pending record updates and response bits
  kltl_pkg::key_flags_t nf, nf_next;
  kltl_pkg::key_rec_t   nr, nr_next;
  logic we_f, we_f_next, we_r, we_r_next;
  logic sw_used, sw_used_next, sw_drop, sw_drop_next;
  logic acc, acc_next, mtap, mtap_next, caps_now, caps_now_next;

  // sweep control
  logic [kltl_pkg::CNT_BITS-1:0] cnt;
  logic                          pend;
  logic [kltl_pkg::KEY_BITS-1:0] sw_addr;

  // memories and their valid bits
  logic                          fl_we, rc_we;
  logic [kltl_pkg::KEY_BITS-1:0] fl_waddr, fl_raddr, rc_raddr, pos_addr;
  kltl_pkg::key_flags_t          fl_wdata, fl_rdata, f_cur, sw_f;
  kltl_pkg::key_rec_t            rc_rdata, r_cur;
  logic [kltl_pkg::KEY_COUNT-1:0] fl_vld, rc_vld;
  logic                          fl_rvld, rc_rvld;

  logic in_range, commit_go;

  kltl_ram #(.WIDTH($bits(kltl_pkg::key_flags_t)), .DEPTH(kltl_pkg::KEY_COUNT)) u_flags (
    .clk   (clk),
    .we    (fl_we),
    .waddr (fl_waddr),
    .wdata (fl_wdata),
    .raddr (fl_raddr),
    .rdata (fl_rdata)
  );

  kltl_ram #(.WIDTH($bits(kltl_pkg::key_rec_t)), .DEPTH(kltl_pkg::KEY_COUNT)) u_recs (
    .clk   (clk),
    .we    (rc_we),
    .waddr (pos_addr),
    .wdata (nr),
    .raddr (rc_raddr),
    .rdata (rc_rdata)
  );

  assign in_range  = {1'b0, req.key_position} < (kltl_pkg::POS_BITS + 1)'(kltl_pkg::KEY_COUNT);
  assign commit_go = !rsp.valid || rsp.ready;
  assign pos_addr  = pos_q[kltl_pkg::KEY_BITS-1:0];
  assign req.ready = (state == ST_IDLE);

  // never-written entries read as zero
  assign f_cur = fl_rvld ? fl_rdata : '0;
  assign r_cur = rc_rvld ? rc_rdata : '0;

  // sweep transform for keys other than the event's own
  always_comb begin
    sw_f = f_cur;
    if (sw_used && f_cur.down && f_cur.magic) begin
      sw_f.used = 1'b1;
    end
    if (sw_drop) begin
      sw_f.taprdy = 1'b0;
      sw_f.elig   = 1'b0;
    end
  end

  // memory ports
  always_comb begin
    rc_raddr = in_range ? req.key_position[kltl_pkg::KEY_BITS-1:0] : '0;
    fl_raddr = (state == ST_SWEEP) ? cnt[kltl_pkg::KEY_BITS-1:0] : rc_raddr;
    if (state == ST_SWEEP) begin
      fl_we    = pend && (sw_addr != pos_addr);
      fl_waddr = sw_addr;
      fl_wdata = sw_f;
    end else begin
      fl_we    = (state == ST_COMMIT) && commit_go && we_f;
      fl_waddr = pos_addr;
      fl_wdata = nf;
    end
    rc_we = (state == ST_COMMIT) && commit_go && we_r;
  end

  // event evaluation on the key's own record
  always_comb begin
    logic [kltl_pkg::TIME_BITS-1:0] start;
    logic [kltl_pkg::TIME_BITS-1:0] diff;
    logic                           is_short;
    logic                           lock;
    logic                           owns;
    logic                           s;
    logic [kltl_pkg::GEN_BITS-1:0]  gen_inc;

    start    = (cmd_q == kltl_pkg::CMD_LAYER_PRESS) ? r_cur.release_t : r_cur.press;
    diff     = now_q - start;
    is_short = (now_q >= start) && (diff <= kltl_pkg::TIME_BITS'(tap_window));
    gen_inc  = gen + 1'b1;
    lock     = 1'b0;
    owns     = 1'b0;
    s        = 1'b0;

    nf_next           = f_cur;
    nr_next           = r_cur;
    we_f_next         = 1'b0;
    we_r_next         = 1'b0;
    sw_used_next      = 1'b0;
    sw_drop_next      = 1'b0;
    acc_next          = 1'b0;
    mtap_next         = 1'b0;
    caps_now_next     = 1'b0;
    active_next       = active_layer;
    locked_next       = locked_layer;
    owner_valid_next  = owner_valid;
    owner_key_next    = owner_key;
    gen_next          = gen;
    caps_set_next     = caps_set;
    shift_cnt_next    = shift_cnt;
    magic_cnt_next    = magic_cnt;

    if (in_range_q) begin
      case (cmd_q)
        kltl_pkg::CMD_LAYER_PRESS: begin
          if ((layer_q inside {kltl_pkg::LAYER_1, kltl_pkg::LAYER_2, kltl_pkg::LAYER_4})
              && !f_cur.down) begin
            acc_next     = 1'b1;
            sw_used_next = 1'b1;
            sw_drop_next = 1'b1;
            we_f_next    = 1'b1;
            we_r_next    = 1'b1;
            nf_next      = '0;
            nf_next.used = f_cur.used;
            nf_next.down = 1'b1;
            nr_next.press = now_q;
            nr_next.layer = layer_q;
            gen_next      = gen_inc;
            if (locked_layer == layer_q) begin
              active_next      = '0;
              locked_next      = kltl_pkg::LAYER_NONE;
              owner_valid_next = 1'b0;
              owner_key_next   = '0;
              nr_next.gen      = '0;
            end else begin
              lock = (f_cur.taprdy && (r_cur.layer == layer_q) && is_short) ||
                     (magic_cnt != '0);
              active_next      = kltl_pkg::ACTIVE_BITS'(layer_q);
              locked_next      = lock ? layer_q : kltl_pkg::LAYER_NONE;
              owner_valid_next = 1'b1;
              owner_key_next   = pos_q;
              nr_next.gen      = gen_inc;
              nf_next.elig     = !lock;
            end
          end
        end
        kltl_pkg::CMD_LAYER_RELEASE: begin
          if (f_cur.down && !f_cur.magic) begin
            owns = owner_valid && (owner_key == pos_q) && (r_cur.gen == gen);
            acc_next     = 1'b1;
            we_f_next    = 1'b1;
            nf_next.down = 1'b0;
            if (owns && (locked_layer == kltl_pkg::LAYER_NONE)) begin
              active_next       = '0;
              locked_next       = kltl_pkg::LAYER_NONE;
              owner_valid_next  = 1'b0;
              owner_key_next    = '0;
              gen_next          = gen_inc;
              nf_next.taprdy    = f_cur.elig && is_short;
              nr_next.release_t = now_q;
              we_r_next         = 1'b1;
            end
            nf_next.elig = 1'b0;
          end
        end
        kltl_pkg::CMD_MAGIC_PRESS: begin
          if (!f_cur.down) begin
            acc_next          = 1'b1;
            sw_used_next      = 1'b1;
            sw_drop_next      = 1'b1;
            we_f_next         = 1'b1;
            we_r_next         = 1'b1;
            nf_next           = '0;
            nf_next.down      = 1'b1;
            nf_next.magic     = 1'b1;
            nf_next.used      = (magic_cnt != '0);
            nr_next.layer     = kltl_pkg::LAYER_NONE;
            nr_next.press     = now_q;
            nr_next.release_t = '0;
            nr_next.gen       = '0;
            magic_cnt_next    = magic_cnt + 1'b1;
            active_next       = magic_layer;
            locked_next       = kltl_pkg::LAYER_NONE;
            owner_valid_next  = 1'b0;
            owner_key_next    = '0;
            gen_next          = gen_inc;
          end
        end
        kltl_pkg::CMD_MAGIC_RELEASE: begin
          if (f_cur.down && f_cur.magic) begin
            acc_next       = 1'b1;
            we_f_next      = 1'b1;
            nf_next.down   = 1'b0;
            mtap_next      = !f_cur.used && is_short;
            magic_cnt_next = magic_cnt - 1'b1;
            if ((active_layer == magic_layer) && (magic_cnt_next == '0)) begin
              active_next      = '0;
              locked_next      = kltl_pkg::LAYER_NONE;
              owner_valid_next = 1'b0;
              owner_key_next   = '0;
              gen_next         = gen_inc;
            end
          end
        end
        kltl_pkg::CMD_ACTIVITY: begin
          acc_next     = 1'b1;
          sw_used_next = 1'b1;
        end
        kltl_pkg::CMD_SHIFT_PRESS: begin
          if (r_cur.shift == kltl_pkg::SHIFT_NONE) begin
            acc_next          = 1'b1;
            we_r_next         = 1'b1;
            nr_next.shift     = side_q ? kltl_pkg::SHIFT_RIGHT : kltl_pkg::SHIFT_LEFT;
            shift_cnt_next[side_q] = shift_cnt[side_q] + 1'b1;
          end
        end
        kltl_pkg::CMD_SHIFT_RELEASE: begin
          if (r_cur.shift != kltl_pkg::SHIFT_NONE) begin
            s                 = (r_cur.shift == kltl_pkg::SHIFT_RIGHT);
            acc_next          = 1'b1;
            we_r_next         = 1'b1;
            nr_next.shift     = kltl_pkg::SHIFT_NONE;
            shift_cnt_next[s] = shift_cnt[s] - 1'b1;
          end
        end
        default: begin
        end
      endcase

      // caps latch on accepted shift events
      if (acc_next && ((cmd_q == kltl_pkg::CMD_SHIFT_PRESS) ||
                       (cmd_q == kltl_pkg::CMD_SHIFT_RELEASE))) begin
        if ((shift_cnt_next[0] == '0) && (shift_cnt_next[1] == '0)) begin
          caps_set_next = 1'b0;
        end
        if ((shift_cnt_next[0] != '0) && (shift_cnt_next[1] != '0) && !caps_set) begin
          caps_set_next = 1'b1;
          caps_now_next = 1'b1;
        end
      end
    end
  end

  // sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    fl_rvld <= fl_vld[fl_raddr];
    rc_rvld <= rc_vld[rc_raddr];
    if (rst) begin
      state        <= ST_IDLE;
      tap_window   <= kltl_pkg::TAP_WINDOW_RST;
      magic_layer  <= kltl_pkg::MAGIC_LAYER_RST;
      active_layer <= '0;
      locked_layer <= kltl_pkg::LAYER_NONE;
      owner_valid  <= 1'b0;
      owner_key    <= '0;
      gen          <= '0;
      caps_set     <= 1'b0;
      shift_cnt[0] <= '0;
      shift_cnt[1] <= '0;
      magic_cnt    <= '0;
      fl_vld       <= '0;
      rc_vld       <= '0;
      pend         <= 1'b0;
      cnt          <= '0;
      rsp.valid    <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          kltl_pkg::CFG_TAP_WINDOW:  tap_window  <= cfg_data;
          kltl_pkg::CFG_MAGIC_LAYER: magic_layer <= cfg_data[kltl_pkg::ACTIVE_BITS-1:0];
          default: begin
          end
        endcase
      end

      if (fl_we) begin
        fl_vld[fl_waddr] <= 1'b1;
      end
      if (rc_we) begin
        rc_vld[pos_addr] <= 1'b1;
      end
      // a response taken outside commit leaves the register empty
      if (rsp.valid && rsp.ready && (state != ST_COMMIT)) begin
        rsp.valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            cmd_q      <= req.cmd;
            pos_q      <= req.key_position;
            layer_q    <= req.layer_number;
            now_q      <= kltl_pkg::TIME_BITS'(req.timestamp_ms);
            side_q     <= req.shift_side;
            in_range_q <= in_range;
            state      <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          nf           <= nf_next;
          nr           <= nr_next;
          we_f         <= we_f_next;
          we_r         <= we_r_next;
          sw_used      <= sw_used_next;
          sw_drop      <= sw_drop_next;
          acc          <= acc_next;
          mtap         <= mtap_next;
          caps_now     <= caps_now_next;
          active_layer <= active_next;
          locked_layer <= locked_next;
          owner_valid  <= owner_valid_next;
          owner_key    <= owner_key_next;
          gen          <= gen_next;
          caps_set     <= caps_set_next;
          shift_cnt    <= shift_cnt_next;
          magic_cnt    <= magic_cnt_next;
          cnt          <= '0;
          pend         <= 1'b0;
          state        <= (sw_used_next || sw_drop_next) ? ST_SWEEP : ST_COMMIT;
        end
        ST_SWEEP: begin
          if (cnt != kltl_pkg::CNT_BITS'(kltl_pkg::KEY_COUNT)) begin
            sw_addr <= cnt[kltl_pkg::KEY_BITS-1:0];
            cnt     <= cnt + 1'b1;
            pend    <= 1'b1;
          end else begin
            pend  <= 1'b0;
            state <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (commit_go) begin
            rsp.valid          <= 1'b1;
            rsp.accepted       <= acc;
            rsp.magic_tap      <= mtap;
            rsp.caps_latch_now <= caps_now;
            rsp.active_layer   <= active_layer;
            rsp.locked_layer   <= locked_layer;
            rsp.owner_valid    <= owner_valid;
            rsp.owner_key      <= owner_key;
            state              <= ST_IDLE;
          end else if (rsp.valid && rsp.ready) begin
            rsp.valid <= 1'b0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  `ASSERT_NEVER(a_magic_cnt_range, clk, rst,
    magic_cnt > kltl_pkg::CNT_BITS'(kltl_pkg::KEY_COUNT))
  `ASSERT_CLK(a_rsp_from_commit, clk, rst,
    $rose(rsp.valid) |-> $past(state == ST_COMMIT))
  `ASSERT_CLK(a_sweep_exit, clk, rst,
    (state == ST_SWEEP) |=> ((state == ST_SWEEP) || (state == ST_COMMIT)))
  `ASSERT_CLK(a_caps_now_latched, clk, rst,
    (rsp.valid && rsp.caps_latch_now && $rose(rsp.valid)) |-> caps_set)

endmodule

// ===== verif/keyboard_layer_tap_lock_controller_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_layer_tap_lock_controller_test
// Self-checking bench for the layer-tap / lock / caps-latch controller.
// A queue-fed driver sends key event requests in random bursts. A monitor
// stalls the response side and checks every response field against an
// in-bench model of the key records and layer state. The tap window and the
// magic layer are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module keyboard_layer_tap_lock_controller_test;
  import kltl_pkg::*;

  localparam logic [CMD_BITS-1:0] CMD_UNUSED = 3'd7;
  localparam int DRAIN_CYCLES = 120;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [CMD_BITS-1:0]   cmd;
    logic [POS_BITS-1:0]   pos;
    logic [LAYER_BITS-1:0] layer;
    logic [TS_BITS-1:0]    ts;
    logic                  side;
  } key_event_t;

  typedef struct packed {
    logic                   accepted;
    logic                   magic_tap;
    logic                   caps_now;
    logic [ACTIVE_BITS-1:0] active;
    logic [LAYER_BITS-1:0]  locked;
    logic                   owner_valid;
    logic [POS_BITS-1:0]    owner_key;
  } layer_resp_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [CFG_BITS-1:0] cfg_data;

  kltl_req_if req_ch ();
  kltl_rsp_if rsp_ch ();

  keyboard_layer_tap_lock_controller u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // model state
  key_flags_t            m_flags [KEY_COUNT];
  logic [LAYER_BITS-1:0] m_layer [KEY_COUNT];
  logic [TIME_BITS-1:0]  m_press [KEY_COUNT];
  logic [TIME_BITS-1:0]  m_rel   [KEY_COUNT];
  logic [GEN_BITS-1:0]   m_gen   [KEY_COUNT];
  logic [1:0]            m_shift [KEY_COUNT];
  logic [SCNT_BITS-1:0]  m_shift_cnt [2];
  logic [ACTIVE_BITS-1:0] m_active;
  logic [LAYER_BITS-1:0]  m_locked;
  logic                   m_owner_valid;
  logic [POS_BITS-1:0]    m_owner;
  logic [GEN_BITS-1:0]    m_gen_ctr;
  logic                   m_caps;
  logic [TAP_BITS-1:0]    m_tap_window;
  logic [ACTIVE_BITS-1:0] m_magic_layer;

  key_event_t  pending_events [$];
  layer_resp_t expected_resps [$];
  int errors, n_sent, n_checked, n_taps, n_caps, n_applied;
  int burst_left, gap_left, idle_cycles;
  bit hold;
  logic [TS_BITS-1:0] cur_t;

  function automatic bit is_tap(logic [TIME_BITS-1:0] t_end, logic [TIME_BITS-1:0] t_start);
    return t_end >= t_start && (t_end - t_start) <= {16'd0, m_tap_window};
  endfunction

  function automatic int held_magic_count();
    int n;
    n = 0;
    for (int i = 0; i < KEY_COUNT; i++)
      if (m_flags[i].down && m_flags[i].magic) n++;
    return n;
  endfunction

  function automatic void mark_magic_used(int pos);
    for (int i = 0; i < KEY_COUNT; i++)
      if (i != pos && m_flags[i].down && m_flags[i].magic) m_flags[i].used = 1'b1;
  endfunction

  function automatic void clear_other_taps(int pos);
    for (int i = 0; i < KEY_COUNT; i++)
      if (i != pos) begin
        m_flags[i].taprdy = 1'b0;
        m_flags[i].elig = 1'b0;
      end
  endfunction

  function automatic void apply_layer(logic [ACTIVE_BITS-1:0] lay, logic [LAYER_BITS-1:0] lck,
                                      logic ov, logic [POS_BITS-1:0] op);
    m_active = lay;
    m_locked = lck;
    m_owner_valid = ov;
    m_owner = ov ? op : '0;
    m_gen_ctr = m_gen_ctr + 1'b1;
  endfunction

  function automatic void reset_model();
    for (int i = 0; i < KEY_COUNT; i++) begin
      m_flags[i] = '0;
      m_layer[i] = '0;
      m_press[i] = '0;
      m_rel[i] = '0;
      m_gen[i] = '0;
      m_shift[i] = SHIFT_NONE;
    end
    m_shift_cnt[0] = '0;
    m_shift_cnt[1] = '0;
    m_active = '0;
    m_locked = LAYER_NONE;
    m_owner_valid = 1'b0;
    m_owner = '0;
    m_gen_ctr = '0;
    m_caps = 1'b0;
    m_tap_window = TAP_WINDOW_RST;
    m_magic_layer = MAGIC_LAYER_RST;
  endfunction

  // apply one key event to the model and return the response it causes
  function automatic layer_resp_t predict_layer_state(key_event_t ev);
    layer_resp_t r;
    key_flags_t f;
    int p;
    bit dbl, lock, owns, used;
    r = '0;
    p = ev.pos;
    if (p < KEY_COUNT) begin
      f = m_flags[p];
      case (ev.cmd)
        CMD_LAYER_PRESS: begin
          if ((ev.layer == LAYER_1 || ev.layer == LAYER_2 || ev.layer == LAYER_4) && !f.down) begin
            dbl = f.taprdy && m_layer[p] == ev.layer && is_tap(ev.ts, m_rel[p]);
            r.accepted = 1'b1;
            mark_magic_used(p);
            clear_other_taps(p);
            m_flags[p] = '0;
            m_flags[p].used = f.used;
            m_flags[p].down = 1'b1;
            m_press[p] = ev.ts;
            m_layer[p] = ev.layer;
            if (m_locked == ev.layer) begin
              apply_layer('0, LAYER_NONE, 1'b0, '0);
              m_gen[p] = '0;
            end else begin
              lock = dbl || held_magic_count() > 0;
              apply_layer({2'b00, ev.layer}, lock ? ev.layer : LAYER_NONE, 1'b1, ev.pos);
              m_gen[p] = m_gen_ctr;
              if (!lock) m_flags[p].elig = 1'b1;
            end
          end
        end
        CMD_LAYER_RELEASE: begin
          if (f.down && !f.magic) begin
            owns = m_owner_valid && m_owner == ev.pos && m_gen[p] == m_gen_ctr;
            r.accepted = 1'b1;
            f.down = 1'b0;
            if (owns && m_locked == LAYER_NONE) begin
              apply_layer('0, LAYER_NONE, 1'b0, '0);
              f.taprdy = f.elig && is_tap(ev.ts, m_press[p]);
              m_rel[p] = ev.ts;
            end
            f.elig = 1'b0;
            m_flags[p] = f;
          end
        end
        CMD_MAGIC_PRESS: begin
          if (!f.down) begin
            r.accepted = 1'b1;
            mark_magic_used(p);
            clear_other_taps(p);
            used = held_magic_count() > 0;
            m_flags[p] = '0;
            m_flags[p].down = 1'b1;
            m_flags[p].magic = 1'b1;
            m_flags[p].used = used;
            m_layer[p] = '0;
            m_press[p] = ev.ts;
            m_rel[p] = '0;
            m_gen[p] = '0;
            apply_layer(m_magic_layer, LAYER_NONE, 1'b0, '0);
          end
        end
        CMD_MAGIC_RELEASE: begin
          if (f.down && f.magic) begin
            r.accepted = 1'b1;
            f.down = 1'b0;
            m_flags[p] = f;
            r.magic_tap = !f.used && is_tap(ev.ts, m_press[p]);
            if (m_active == m_magic_layer && held_magic_count() == 0)
              apply_layer('0, LAYER_NONE, 1'b0, '0);
          end
        end
        CMD_ACTIVITY: begin
          r.accepted = 1'b1;
          mark_magic_used(p);
        end
        CMD_SHIFT_PRESS, CMD_SHIFT_RELEASE: begin
          if (ev.cmd == CMD_SHIFT_PRESS && m_shift[p] == SHIFT_NONE) begin
            r.accepted = 1'b1;
            m_shift[p] = ev.side ? SHIFT_RIGHT : SHIFT_LEFT;
            m_shift_cnt[ev.side] = m_shift_cnt[ev.side] + 1'b1;
          end else if (ev.cmd == CMD_SHIFT_RELEASE && m_shift[p] != SHIFT_NONE) begin
            r.accepted = 1'b1;
            m_shift_cnt[m_shift[p] == SHIFT_RIGHT] = m_shift_cnt[m_shift[p] == SHIFT_RIGHT] - 1'b1;
            m_shift[p] = SHIFT_NONE;
          end
          if (r.accepted) begin
            if (m_shift_cnt[0] == 0 && m_shift_cnt[1] == 0) m_caps = 1'b0;
            if (m_shift_cnt[0] != 0 && m_shift_cnt[1] != 0 && !m_caps) begin
              m_caps = 1'b1;
              r.caps_now = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
    r.active = m_active;
    r.locked = m_locked;
    r.owner_valid = m_owner_valid;
    r.owner_key = m_owner_valid ? m_owner : '0;
    return r;
  endfunction

  task automatic add_event(logic [CMD_BITS-1:0] cmd, int pos, logic [LAYER_BITS-1:0] layer,
                           logic [TS_BITS-1:0] ts, logic side);
    key_event_t ev;
    ev.cmd = cmd;
    ev.pos = pos[POS_BITS-1:0];
    ev.layer = layer;
    ev.ts = ts;
    ev.side = side;
    pending_events.push_back(ev);
  endtask

  // mostly event sequences on a few keys with times near the tap window
  task automatic add_random_events(int n);
    int pos, sel;
    logic [CMD_BITS-1:0] cmd;
    logic [LAYER_BITS-1:0] layer;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 85) pos = $urandom_range(0, 5);
      else if (sel < 93) pos = $urandom_range(KEY_COUNT - 4, KEY_COUNT - 1);
      else pos = $urandom_range(KEY_COUNT, 127);
      sel = $urandom_range(0, 99);
      if (sel < 2) cmd = CMD_UNUSED;
      else cmd = CMD_BITS'($urandom_range(0, 6));
      sel = $urandom_range(0, 9);
      case (sel)
        0, 1, 2: layer = LAYER_1;
        3, 4, 5: layer = LAYER_2;
        6, 7:    layer = LAYER_4;
        default: layer = LAYER_BITS'($urandom_range(0, 7));
      endcase
      sel = $urandom_range(0, 49);
      if (sel == 0) cur_t = $urandom;
      else if (sel < 10) cur_t = cur_t + $urandom_range(0, 70000);
      else cur_t = cur_t + $urandom_range(0, 2 * m_tap_window + 20);
      add_event(cmd, pos, layer, cur_t, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic wait_drained();
    while (pending_events.size() != 0 || expected_resps.size() != 0 || req_ch.valid)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_BITS-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_TAP_WINDOW) m_tap_window = val;
    else m_magic_layer = val[ACTIVE_BITS-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // request driver: bursts with random gaps, model updated on each accept
  always @(posedge clk) begin
    key_event_t ev;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        ev.cmd = req_ch.cmd;
        ev.pos = req_ch.key_position;
        ev.layer = req_ch.layer_number;
        ev.ts = req_ch.timestamp_ms;
        ev.side = req_ch.shift_side;
        expected_resps.push_back(predict_layer_state(ev));
        n_sent++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_ch.valid <= 1'b0;
        end else if (pending_events.size() != 0 && !hold) begin
          ev = pending_events.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.cmd <= ev.cmd;
          req_ch.key_position <= ev.pos;
          req_ch.layer_number <= ev.layer;
          req_ch.timestamp_ms <= ev.ts;
          req_ch.shift_side <= ev.side;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
          end else begin
            burst_left--;
          end
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor with its own stall pattern
  int stall_mode, stall_timer;
  always @(posedge clk) begin
    layer_resp_t got, exp_r;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.accepted = rsp_ch.accepted;
        got.magic_tap = rsp_ch.magic_tap;
        got.caps_now = rsp_ch.caps_latch_now;
        got.active = rsp_ch.active_layer;
        got.locked = rsp_ch.locked_layer;
        got.owner_valid = rsp_ch.owner_valid;
        got.owner_key = rsp_ch.owner_key;
        if (expected_resps.size() == 0) begin
          $display("%0t: response with no request outstanding: %p", $realtime, got);
          errors++;
        end else begin
          exp_r = expected_resps.pop_front();
          n_checked++;
          if (got.magic_tap) n_taps++;
          if (got.caps_now) n_caps++;
          if (got.accepted) n_applied++;
          if (got.accepted !== exp_r.accepted || got.magic_tap !== exp_r.magic_tap ||
              got.caps_now !== exp_r.caps_now || got.active !== exp_r.active ||
              got.locked !== exp_r.locked || got.owner_valid !== exp_r.owner_valid ||
              got.owner_key !== exp_r.owner_key) begin
            $display("%0t: response mismatch: expected %p actual %p", $realtime, exp_r, got);
            errors++;
          end
        end
      end
      if (stall_timer == 0) begin
        stall_timer = $urandom_range(20, 300);
        stall_mode = $urandom_range(0, 2);
      end else begin
        stall_timer--;
      end
      case (stall_mode)
        0:       rsp_ch.ready <= 1'b1;
        1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $realtime, idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus and phases
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_TAP_WINDOW;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_LAYER_PRESS;
    req_ch.key_position = '0;
    req_ch.layer_number = '0;
    req_ch.timestamp_ms = '0;
    req_ch.shift_side = 1'b0;
    rsp_ch.ready = 1'b0;
    errors = 0; n_sent = 0; n_checked = 0; n_taps = 0; n_caps = 0; n_applied = 0;
    burst_left = 0; gap_left = 0; idle_cycles = 0; stall_mode = 0; stall_timer = 0;
    hold = 1'b0;
    cur_t = 32'd1000;
    reset_model();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: tap then double tap locks, press of locked key unlocks
    add_event(CMD_LAYER_PRESS,   0, LAYER_1, 32'd100, 1'b0);
    add_event(CMD_LAYER_RELEASE, 0, LAYER_1, 32'd150, 1'b0);
    add_event(CMD_LAYER_PRESS,   0, LAYER_1, 32'd200, 1'b0);
    add_event(CMD_LAYER_PRESS,   0, LAYER_1, 32'd210, 1'b0);   // held: ignored
    add_event(CMD_LAYER_RELEASE, 0, LAYER_1, 32'd220, 1'b0);
    add_event(CMD_LAYER_PRESS,   0, LAYER_1, 32'd230, 1'b0);   // unlock
    add_event(CMD_LAYER_RELEASE, 0, LAYER_1, 32'd240, 1'b0);
    add_event(CMD_LAYER_PRESS,   1, 3'd3,    32'd250, 1'b0);   // bad layer
    add_event(CMD_LAYER_RELEASE, 3, LAYER_1, 32'd255, 1'b0);   // not held
    // magic held locks a layer; magic tap and used magic
    add_event(CMD_MAGIC_PRESS,   5, 3'd7,    32'd300, 1'b1);
    add_event(CMD_MAGIC_PRESS,   5, LAYER_2, 32'd301, 1'b0);   // held: ignored
    add_event(CMD_LAYER_PRESS,   1, LAYER_4, 32'd310, 1'b0);
    add_event(CMD_LAYER_RELEASE, 5, LAYER_1, 32'd315, 1'b0);   // magic: ignored
    add_event(CMD_MAGIC_RELEASE, 5, LAYER_1, 32'd320, 1'b0);
    add_event(CMD_LAYER_PRESS,   1, LAYER_4, 32'd330, 1'b0);   // held
    add_event(CMD_MAGIC_PRESS,   6, LAYER_1, 32'd400, 1'b0);
    add_event(CMD_MAGIC_RELEASE, 6, LAYER_1, 32'd450, 1'b0);   // clean tap
    add_event(CMD_MAGIC_PRESS,   KEY_COUNT - 1, LAYER_1, 32'hFFFF_FF00, 1'b0);
    add_event(CMD_ACTIVITY,      7, LAYER_2, 32'hFFFF_FFF0, 1'b1);
    add_event(CMD_MAGIC_RELEASE, KEY_COUNT - 1, LAYER_1, 32'hFFFF_FFFF, 1'b0);
    add_event(CMD_MAGIC_RELEASE, 4, LAYER_1, 32'd0, 1'b0);     // not magic
    // shifts: both sides latch caps once
    add_event(CMD_SHIFT_PRESS,   10, LAYER_1, 32'd500, 1'b0);
    add_event(CMD_SHIFT_PRESS,   10, LAYER_1, 32'd501, 1'b1);  // already held
    add_event(CMD_SHIFT_PRESS,   11, LAYER_1, 32'd502, 1'b1);
    add_event(CMD_SHIFT_RELEASE, 12, LAYER_1, 32'd503, 1'b0);  // not held
    add_event(CMD_SHIFT_RELEASE, 10, LAYER_1, 32'd504, 1'b0);
    add_event(CMD_SHIFT_RELEASE, 11, LAYER_1, 32'd505, 1'b0);
    add_event(CMD_ACTIVITY,      127, LAYER_4, 32'd506, 1'b1); // out of range
    add_event(CMD_UNUSED,        2, LAYER_1, 32'd507, 1'b0);
    wait_drained();

    // random phases, block idle between settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin write_reg(CFG_TAP_WINDOW, 16'd0);     write_reg(CFG_MAGIC_LAYER, 16'd31); end
        1: begin write_reg(CFG_TAP_WINDOW, 16'hFFFF);  write_reg(CFG_MAGIC_LAYER, 16'd0);  end
        2: begin write_reg(CFG_TAP_WINDOW, 16'd200);   write_reg(CFG_MAGIC_LAYER, 16'd4);  end
        default: begin
          write_reg(CFG_TAP_WINDOW, CFG_BITS'($urandom_range(1, 600)));
          write_reg(CFG_MAGIC_LAYER, CFG_BITS'($urandom_range(0, 31)));
        end
      endcase
      add_random_events(105);
      wait_drained();
    end

    $display("Sent %0d events, checked %0d responses (%0d applied, %0d magic taps, %0d caps latches)",
             n_sent, n_checked, n_applied, n_taps, n_caps);
    $display("Covered tap windows 0, 200, 65535 and random, magic layers 0, 31 and others");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/kltl_pkg.sv
rtl/kltl_ifs.sv
rtl/kltl_ram.sv
rtl/keyboard_layer_tap_lock_controller.sv
verif/keyboard_layer_tap_lock_controller_test.sv
